// ===== rtl/glmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmr_pkg
// Shared types and constants of the gaussian line model residual core.
// ----------------------------------------------------------------------------
package glmr_pkg;

	typedef enum logic [2:0] {
		REG_TAU   = 3'd0,
		REG_VC    = 3'd1,
		REG_SIGMA = 3'd2,
		REG_TEX   = 3'd3,
		REG_FREQ  = 3'd4,
		REG_WLO   = 3'd5,
		REG_WHI   = 3'd6
	} glmr_reg_t;

	typedef struct packed {
		logic [31:0] peak_optical_depth;
		logic [31:0] line_center_velocity;
		logic [31:0] line_width;
		logic [31:0] excitation_temp;
		logic [31:0] frequency_khz;
		logic [31:0] window_low;
		logic [31:0] window_high;
	} glmr_cfg_t;

	// classified channel handed from front to back
	typedef struct packed {
		logic [31:0] observed_temp;
		logic [32:0] mag;
		logic        in_window;
		logic        rejected;
		logic        last;
	} glmr_item_t;

	localparam logic [31:0] RST_TAU   = 32'h0000_0000;
	localparam logic [31:0] RST_VC    = 32'h0000_0000;
	localparam logic [31:0] RST_SIGMA = 32'h0001_0000;
	localparam logic [31:0] RST_TEX   = 32'h000A_0000;
	localparam logic [31:0] RST_FREQ  = 32'h0000_0000;
	localparam logic [31:0] RST_WLO   = 32'hFF9C_0000;
	localparam logic [31:0] RST_WHI   = 32'h0064_0000;

	localparam logic [32:0] ONE32    = 33'h1_0000_0000;
	localparam logic [62:0] SUM_MAX  = {63{1'b1}};
	localparam logic [30:0] EXP_M1   = 31'd1580030169;
	localparam logic [31:0] HK_KHZ   = 32'd3458199341;
	localparam logic [32:0] DIV3_REC = 33'd5726623061;
	localparam logic [31:0] AMP_MAX  = 32'h7FFF_FFFF;
	localparam int          EXP_K_MAX = 23;
	localparam int          GAUSS_LIM = 7;
	localparam int          DIV_STEPS = 65;
	localparam int          EXP_TERMS = 12;
	localparam int          FIFO_DEPTH = 2;

	// floor(2^32 / n) for the series terms
	function automatic logic [32:0] rec_n(input logic [3:0] n);
		logic [32:0] r;
		case (n)
			4'd1:    r = 33'd4294967296;
			4'd2:    r = 33'd2147483648;
			4'd3:    r = 33'd1431655765;
			4'd4:    r = 33'd1073741824;
			4'd5:    r = 33'd858993459;
			4'd6:    r = 33'd715827882;
			4'd7:    r = 33'd613566756;
			4'd8:    r = 33'd536870912;
			4'd9:    r = 33'd477218588;
			4'd10:   r = 33'd429496729;
			4'd11:   r = 33'd390451572;
			4'd12:   r = 33'd357913941;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/glmr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmr_front
// Accepts channels, checks the parameters and the velocity window.
// ----------------------------------------------------------------------------
module glmr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  glmr_pkg::glmr_cfg_t  cfg,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  logic [31:0]          s_velocity,
	input  logic [31:0]          s_observed,
	input  logic                 s_last,
	output logic                 push,
	output glmr_pkg::glmr_item_t push_item,
	input  logic                 full
);
	import glmr_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_CLS} fstate_t;

	fstate_t     state_q;
	logic [31:0] vel_q;
	logic [31:0] obs_q;
	logic        last_q;
	logic [32:0] x_q;
	logic        neg_q;
	logic [31:0] qe_q;

	logic signed [32:0] diff;
	logic [32:0]        x;
	logic [65:0]        prod;
	logic [33:0]        rem;
	logic [32:0]        q;
	logic signed [34:0] third;
	logic signed [34:0] lo;
	logic signed [34:0] hi;
	logic signed [34:0] vc35;
	logic signed [32:0] dv;
	logic               rej;
	logic               inwin;

	assign diff = $signed({cfg.window_high[31], cfg.window_high})
		- $signed({cfg.window_low[31], cfg.window_low});
	assign x    = diff[32] ? 33'(-diff) : 33'(diff);
	assign prod = 66'(x) * 66'(DIV3_REC);

	always_comb begin
		rem   = {1'b0, x_q} - 34'(qe_q) * 34'd3;
		q     = (rem >= 34'd3) ? 33'(qe_q) + 33'd1 : 33'(qe_q);
		third = neg_q ? -$signed({2'b00, q}) : $signed({2'b00, q});
		lo    = $signed({{3{cfg.window_low[31]}}, cfg.window_low}) + third;
		hi    = $signed({{3{cfg.window_high[31]}}, cfg.window_high}) - third;
		vc35  = $signed({{3{cfg.line_center_velocity[31]}}, cfg.line_center_velocity});
		rej   = cfg.line_width[31] | cfg.peak_optical_depth[31] | (vc35 < lo) | (vc35 > hi);
		inwin = ($signed(vel_q) > $signed(cfg.window_low))
			&& ($signed(vel_q) < $signed(cfg.window_high));
		dv    = $signed({vel_q[31], vel_q})
			- $signed({cfg.line_center_velocity[31], cfg.line_center_velocity});
	end

	assign s_ready                 = (state_q == F_IDLE);
	assign push                    = (state_q == F_CLS) && !full;
	assign push_item.observed_temp = obs_q;
	assign push_item.mag           = dv[32] ? 33'(-dv) : 33'(dv);
	assign push_item.in_window     = inwin;
	assign push_item.rejected      = rej;
	assign push_item.last          = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_valid) begin
						vel_q   <= s_velocity;
						obs_q   <= s_observed;
						last_q  <= s_last;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					x_q     <= x;
					neg_q   <= diff[32];
					qe_q    <= prod[65:34];
					state_q <= F_CLS;
				end
				F_CLS: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/glmr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmr_fifo
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module glmr_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  glmr_pkg::glmr_item_t push_data,
	output logic                 full,
	input  logic                 pop,
	output glmr_pkg::glmr_item_t pop_data,
	output logic                 empty
);
	import glmr_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	glmr_item_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full     = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("request queue overflow");

endmodule

// ===== rtl/glmr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmr_div
// Shared restoring divider, one quotient bit a cycle, saturating at 64 bits.
// ----------------------------------------------------------------------------
module glmr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [64:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [63:0] quot
);
	import glmr_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [64:0]      num_q;
	logic [32:0]      den_q;
	logic [32:0]      rem_q;
	logic [64:0]      quo_q;

	logic [33:0] rem_sh;
	logic        ge;
	logic [33:0] rem_nx;

	assign rem_sh = {rem_q, num_q[64]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	assign done   = done_q;
	assign quot   = quo_q[64] ? {64{1'b1}} : quo_q[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(DIV_STEPS-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[63:0], 1'b0};
			rem_q <= rem_nx[32:0];
			quo_q <= {quo_q[63:0], ge};
		end
	end

endmodule

// ===== rtl/glmr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmr_back
// Sequencer that evaluates the line model and the residual sum per channel.
// ----------------------------------------------------------------------------
module glmr_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  glmr_pkg::glmr_cfg_t  cfg,
	input  glmr_pkg::glmr_item_t item,
	input  logic                 empty,
	output logic                 pop,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic [31:0]          m_model,
	output logic [62:0]          m_sum,
	output logic                 m_inwin,
	output logic                 m_rej,
	output logic                 m_last
);
	import glmr_pkg::*;

	localparam longint unsigned TBG_FULL = ((64'd2730 << FRAC_BITS) + 64'd500) / 64'd1000;
	localparam logic [31:0]     TBG_Q    = 32'(TBG_FULL);
	localparam int              T0_SHIFT = 56 - FRAC_BITS;

	typedef enum logic [4:0] {
		S_IDLE, S_J0, S_J1, S_J2, S_J3, S_J4, S_JEND,
		S_CHK, S_G1, S_G2, S_G3, S_ATT0, S_ATT1, S_MOD, S_RES, S_ACC, S_OUT,
		S_EX0, S_EX1, S_EX2, S_EX3, S_EX4
	} bstate_t;

	typedef enum logic [1:0] {RET_J, RET_G, RET_A} ret_t;

	bstate_t     state_q;
	ret_t        ret_q;
	glmr_item_t  item_q;
	logic        first_q;
	logic [31:0] amp_q;
	logic [62:0] acc_q;
	logic        jsel_q;
	logic [31:0] jtex_q;
	logic [31:0] jres_q;
	logic [31:0] t0_q;
	logic [63:0] x_q;
	logic [31:0] f_q;
	logic [32:0] p_q;
	logic [31:0] v_q;
	logic [31:0] qe_q;
	logic [3:0]  n_q;
	logic [4:0]  kcnt_q;
	logic [32:0] gauss_q;
	logic [32:0] att_q;
	logic [30:0] u28_q;
	logic [31:0] model_q;
	logic [62:0] sq_q;
	logic        m_valid_q;
	logic [31:0] m_model_q;
	logic [62:0] m_sum_q;
	logic        m_inwin_q;
	logic        m_rej_q;
	logic        m_last_q;

	logic [33:0]        mul_a;
	logic [33:0]        mul_b;
	logic [67:0]        prod;
	logic               div_start;
	logic [64:0]        div_num;
	logic [32:0]        div_den;
	logic               div_done;
	logic [63:0]        div_quot;
	logic [31:0]        t_sel;
	logic [31:0]        amag;
	logic [31:0]        mres;
	logic signed [32:0] r;
	logic [32:0]        rm;
	logic [35:0]        nq;
	logic [35:0]        rem_e;
	logic [32:0]        qv;
	logic signed [32:0] amp_full;
	logic [63:0]        acc_sum;
	logic               load_out;
	bstate_t            ret_st;

	glmr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign prod     = 68'(mul_a) * 68'(mul_b);
	assign t_sel    = jsel_q ? TBG_Q : cfg.excitation_temp;
	assign amag     = amp_q[31] ? 32'(-amp_q) : amp_q;
	assign mres     = prod[63:32];
	assign r        = $signed({item_q.observed_temp[31], item_q.observed_temp})
		- $signed({model_q[31], model_q});
	assign rm       = r[32] ? 33'(-r) : 33'(r);
	assign nq       = 36'(qe_q) * 36'(n_q);
	assign rem_e    = 36'(v_q) - nq;
	assign qv       = (rem_e >= 36'(n_q)) ? 33'(qe_q) + 33'd1 : 33'(qe_q);
	assign amp_full = $signed({1'b0, jtex_q}) - $signed({1'b0, jres_q});
	assign acc_sum  = {1'b0, acc_q} + {1'b0, sq_q};
	assign load_out = (state_q == S_OUT) && (!m_valid_q || m_ready);
	assign pop      = (state_q == S_IDLE) && !empty;

	always_comb begin
		case (ret_q)
			RET_J:   ret_st = S_J3;
			RET_G:   ret_st = S_G3;
			RET_A:   ret_st = S_ATT1;
			default: ret_st = S_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_J0: begin
				mul_a = 34'(cfg.frequency_khz);
				mul_b = 34'(HK_KHZ);
			end
			S_J3: begin
				mul_a = 34'(t0_q);
				mul_b = 34'(p_q);
			end
			S_G2: begin
				mul_a = 34'(u28_q);
				mul_b = 34'(u28_q);
			end
			S_ATT0: begin
				mul_a = 34'(cfg.peak_optical_depth[30:0]);
				mul_b = 34'(gauss_q);
			end
			S_MOD: begin
				mul_a = 34'(amag);
				mul_b = 34'(att_q);
			end
			S_RES: begin
				mul_a = 34'(rm);
				mul_b = 34'(rm);
			end
			S_EX1: begin
				mul_a = 34'(f_q);
				mul_b = 34'(p_q);
			end
			S_EX2: begin
				mul_a = 34'(v_q);
				mul_b = 34'(rec_n(n_q));
			end
			S_EX4: begin
				mul_a = 34'(p_q);
				mul_b = 34'(EXP_M1);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_J1: begin
				div_start = 1'b1;
				div_num   = {1'b0, t0_q, 32'd0};
				div_den   = {1'b0, t_sel};
			end
			S_J3: begin
				div_start = (p_q != '0) && (p_q != ONE32);
				div_num   = prod[64:0];
				div_den   = ONE32 - p_q;
			end
			S_CHK: begin
				div_start = !item_q.rejected && (cfg.line_width != '0);
				div_num   = {item_q.mag, 32'd0};
				div_den   = {2'b00, cfg.line_width[30:0]};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign m_valid = m_valid_q;
	assign m_model = m_model_q;
	assign m_sum   = m_sum_q;
	assign m_inwin = m_inwin_q;
	assign m_rej   = m_rej_q;
	assign m_last  = m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			first_q   <= 1'b1;
			amp_q     <= '0;
			acc_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (load_out) m_valid_q <= 1'b1;
			else if (m_ready) m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						item_q  <= item;
						jsel_q  <= 1'b0;
						state_q <= first_q ? S_J0 : S_CHK;
					end
				end
				S_J0: begin
					if (t_sel == '0) begin
						jres_q  <= '0;
						state_q <= S_JEND;
					end else if (cfg.frequency_khz == '0) begin
						jres_q  <= t_sel;
						state_q <= S_JEND;
					end else begin
						t0_q    <= 32'(prod >> T0_SHIFT);
						state_q <= S_J1;
					end
				end
				S_J1: state_q <= S_J2;
				S_J2: begin
					if (div_done) begin
						x_q     <= div_quot;
						ret_q   <= RET_J;
						state_q <= S_EX0;
					end
				end
				S_J3: begin
					if (p_q == '0) begin
						jres_q  <= '0;
						state_q <= S_JEND;
					end else if (p_q == ONE32) begin
						jres_q  <= t_sel;
						state_q <= S_JEND;
					end else begin
						state_q <= S_J4;
					end
				end
				S_J4: begin
					if (div_done) begin
						jres_q  <= (div_quot > 64'(t_sel)) ? t_sel : div_quot[31:0];
						state_q <= S_JEND;
					end
				end
				S_JEND: begin
					if (!jsel_q) begin
						jtex_q  <= jres_q;
						jsel_q  <= 1'b1;
						state_q <= S_J0;
					end else begin
						amp_q   <= (amp_full > $signed({1'b0, AMP_MAX})) ? AMP_MAX
							: amp_full[31:0];
						first_q <= 1'b0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (item_q.rejected) begin
						model_q <= '0;
						state_q <= S_OUT;
					end else if (cfg.line_width == '0) begin
						gauss_q <= (item_q.mag == '0) ? ONE32 : '0;
						state_q <= S_ATT0;
					end else begin
						state_q <= S_G1;
					end
				end
				S_G1: begin
					if (div_done) begin
						if (div_quot >= {32'(GAUSS_LIM), 32'd0}) begin
							gauss_q <= '0;
							state_q <= S_ATT0;
						end else begin
							u28_q   <= div_quot[34:4];
							state_q <= S_G2;
						end
					end
				end
				S_G2: begin
					x_q     <= 64'(prod >> 25);
					ret_q   <= RET_G;
					state_q <= S_EX0;
				end
				S_G3: begin
					gauss_q <= p_q;
					state_q <= S_ATT0;
				end
				S_ATT0: begin
					x_q     <= 64'(prod >> FRAC_BITS);
					ret_q   <= RET_A;
					state_q <= S_EX0;
				end
				S_ATT1: begin
					att_q   <= ONE32 - p_q;
					state_q <= S_MOD;
				end
				S_MOD: begin
					model_q <= amp_q[31] ? 32'(-mres) : mres;
					state_q <= S_RES;
				end
				S_RES: begin
					sq_q    <= prod[63] ? SUM_MAX : prod[62:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (item_q.in_window) acc_q <= acc_sum[63] ? SUM_MAX : acc_sum[62:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						m_model_q <= item_q.rejected ? '0 : model_q;
						m_sum_q   <= item_q.rejected ? SUM_MAX : acc_q;
						m_inwin_q <= item_q.in_window;
						m_rej_q   <= item_q.rejected;
						m_last_q  <= item_q.last;
						if (item_q.last) begin
							acc_q   <= '0;
							first_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_EX0: begin
					if (x_q[63:32] >= 32'(EXP_K_MAX)) begin
						p_q     <= '0;
						state_q <= ret_st;
					end else begin
						f_q     <= x_q[31:0];
						p_q     <= ONE32;
						n_q     <= 4'(EXP_TERMS);
						kcnt_q  <= '0;
						state_q <= S_EX1;
					end
				end
				S_EX1: begin
					v_q     <= prod[63:32];
					state_q <= S_EX2;
				end
				S_EX2: begin
					qe_q    <= prod[63:32];
					state_q <= S_EX3;
				end
				S_EX3: begin
					p_q <= ONE32 - qv;
					if (n_q == 4'd1) begin
						state_q <= S_EX4;
					end else begin
						n_q     <= n_q - 4'd1;
						state_q <= S_EX1;
					end
				end
				S_EX4: begin
					if (kcnt_q == x_q[36:32]) begin
						state_q <= ret_st;
					end else begin
						p_q    <= 33'((prod + 68'h8000_0000) >> 32);
						kcnt_q <= kcnt_q + 5'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rej_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_rej_q) |-> (m_sum_q == SUM_MAX && m_model_q == '0))
		else $error("rejected result carries model or sum");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && item_q.last) |=> (acc_q == '0 && first_q))
		else $error("spectrum state not cleared after last channel");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_J2 || state_q == S_J4 || state_q == S_G1))
		else $error("divider finished outside a waiting state");

endmodule

// ===== rtl/gaussian_line_model_residual_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_line_model_residual_core
// Gaussian line model brightness and windowed squared residual sum per channel.
// ----------------------------------------------------------------------------
// Sequence: the front registers a channel and classifies it; the back end then
//   uses the shared divider and up to two exponentials per channel; the first
//   channel of a spectrum first works out both radiation temperatures; a
//   rejected channel goes straight to the output.
// Throughput: one channel per back-end sequence; the front queues two ahead.
// Reset: registers take their defaults, sum cleared, no clearing pass.
module gaussian_line_model_residual_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // channel_velocity, observed_temp
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // model_temp, residual_sum, zero pad
	output logic [1:0]  m_axis_tuser,   // in_window, rejected
	output logic        m_axis_tlast
);
	import glmr_pkg::*;

	glmr_cfg_t  cfg_q;
	glmr_item_t push_item;
	glmr_item_t pop_item;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;
	logic [31:0] model;
	logic [62:0] sum;
	logic        inwin;
	logic        rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_optical_depth   <= RST_TAU;
			cfg_q.line_center_velocity <= RST_VC;
			cfg_q.line_width           <= RST_SIGMA;
			cfg_q.excitation_temp      <= RST_TEX;
			cfg_q.frequency_khz        <= RST_FREQ;
			cfg_q.window_low           <= RST_WLO;
			cfg_q.window_high          <= RST_WHI;
		end else if (cfg_we) begin
			case (glmr_reg_t'(cfg_addr))
				REG_TAU:   cfg_q.peak_optical_depth   <= cfg_wdata;
				REG_VC:    cfg_q.line_center_velocity <= cfg_wdata;
				REG_SIGMA: cfg_q.line_width           <= cfg_wdata;
				REG_TEX:   cfg_q.excitation_temp      <= cfg_wdata;
				REG_FREQ:  cfg_q.frequency_khz        <= cfg_wdata;
				REG_WLO:   cfg_q.window_low           <= cfg_wdata;
				REG_WHI:   cfg_q.window_high          <= cfg_wdata;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	glmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_velocity(s_axis_tdata[31:0]),
		.s_observed(s_axis_tdata[63:32]),
		.s_last    (s_axis_tlast),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	glmr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_item),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_item),
		.empty    (empty)
	);

	glmr_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (pop_item),
		.empty  (empty),
		.pop    (pop),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_model(model),
		.m_sum  (sum),
		.m_inwin(inwin),
		.m_rej  (rej),
		.m_last (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, sum, model};
	assign m_axis_tuser = {rej, inwin};

endmodule
